// ===== rtl/core/phc_pkg.sv =====
// Shared types and constants for the packet header checker.
`timescale 1ns / 1ps
`default_nettype none

package phc_pkg;

    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] HDR_LEN   = 13'd12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;
    localparam logic [COUNT_W-1:0] COUNT_INC = 13'd1;

    // Header byte positions
    localparam logic [3:0] POS_CHECKSUM = 4'd0;
    localparam logic [3:0] POS_TYPE_VER = 4'd1;
    localparam logic [3:0] POS_LEN_LO   = 4'd2;
    localparam logic [3:0] POS_LEN_HI   = 4'd3;
    localparam logic [3:0] POS_ID_0     = 4'd4;
    localparam logic [3:0] POS_ID_1     = 4'd5;
    localparam logic [3:0] POS_ID_2     = 4'd6;
    localparam logic [3:0] POS_ID_3     = 4'd7;
    localparam logic [3:0] POS_TIME_0   = 4'd8;
    localparam logic [3:0] POS_TIME_1   = 4'd9;
    localparam logic [3:0] POS_TIME_2   = 4'd10;
    localparam logic [3:0] POS_TIME_3   = 4'd11;

    localparam int TDATA_W = 104;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_LEN_ERR   = 2'd2,
        STATUS_CHECK_ERR = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [3:0]        msg_kind;
        logic [3:0]        version;
        logic [3:0]        channel;
        logic [11:0]       declared_len;
        logic [31:0]       serial_id;
        logic [31:0]       send_time;
        logic [COUNT_W-1:0] total_length;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/phc_hdr_acc.sv =====
// Header byte capture, running checksum, byte count and status decision.
`timescale 1ns / 1ps
`default_nettype none

module phc_hdr_acc (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  res_valid,
    output phc_pkg::result_t      res
);

    logic [phc_pkg::COUNT_W-1:0] count_reg, count_next, count_upd;
    logic [7:0]  sum_reg, sum_next, sum_upd;
    logic [7:0]  chk_reg, chk_next, chk_upd;
    logic [7:0]  tv_reg, tv_next, tv_upd;
    logic [15:0] lc_reg, lc_next, lc_upd;
    logic [31:0] id_reg, id_next, id_upd;
    logic [31:0] time_reg, time_next, time_upd;
    logic [3:0]  hdr_pos;
    logic        in_header;
    logic [phc_pkg::COUNT_W-1:0] excess;

    assign hdr_pos   = count_reg[3:0];
    assign in_header = count_reg < phc_pkg::HDR_LEN;

    // State after this byte, before the end-of-datagram clear
    always_comb begin
        count_upd = count_reg;
        sum_upd   = sum_reg;
        chk_upd   = chk_reg;
        tv_upd    = tv_reg;
        lc_upd    = lc_reg;
        id_upd    = id_reg;
        time_upd  = time_reg;
        if (in_header) begin
            if (hdr_pos != phc_pkg::POS_CHECKSUM) begin
                sum_upd = sum_reg + data_byte;
            end
            unique case (hdr_pos)
                phc_pkg::POS_CHECKSUM: chk_upd         = data_byte;
                phc_pkg::POS_TYPE_VER: tv_upd          = data_byte;
                phc_pkg::POS_LEN_LO:   lc_upd[7:0]     = data_byte;
                phc_pkg::POS_LEN_HI:   lc_upd[15:8]    = data_byte;
                phc_pkg::POS_ID_0:     id_upd[7:0]     = data_byte;
                phc_pkg::POS_ID_1:     id_upd[15:8]    = data_byte;
                phc_pkg::POS_ID_2:     id_upd[23:16]   = data_byte;
                phc_pkg::POS_ID_3:     id_upd[31:24]   = data_byte;
                phc_pkg::POS_TIME_0:   time_upd[7:0]   = data_byte;
                phc_pkg::POS_TIME_1:   time_upd[15:8]  = data_byte;
                phc_pkg::POS_TIME_2:   time_upd[23:16] = data_byte;
                phc_pkg::POS_TIME_3:   time_upd[31:24] = data_byte;
                default: ;
            endcase
        end
        if (count_reg != phc_pkg::COUNT_MAX) begin
            count_upd = count_reg + phc_pkg::COUNT_INC;
        end
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        chk_next   = chk_reg;
        tv_next    = tv_reg;
        lc_next    = lc_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        if (accept) begin
            if (last_byte) begin
                count_next = '0;
                sum_next   = '0;
                chk_next   = '0;
                tv_next    = '0;
                lc_next    = '0;
                id_next    = '0;
                time_next  = '0;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
                chk_next   = chk_upd;
                tv_next    = tv_upd;
                lc_next    = lc_upd;
                id_next    = id_upd;
                time_next  = time_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            chk_reg   <= '0;
            tv_reg    <= '0;
            lc_reg    <= '0;
            id_reg    <= '0;
            time_reg  <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            chk_reg   <= chk_next;
            tv_reg    <= tv_next;
            lc_reg    <= lc_next;
            id_reg    <= id_next;
            time_reg  <= time_next;
        end
    end

    assign excess = count_upd - phc_pkg::HDR_LEN;

    always_comb begin
        res_valid          = accept && last_byte;
        res.msg_kind       = tv_upd[7:4];
        res.version        = tv_upd[3:0];
        res.channel        = lc_upd[3:0];
        res.declared_len   = lc_upd[15:4];
        res.serial_id      = id_upd;
        res.send_time      = time_upd;
        res.total_length   = count_upd;
        // too short first, then length mismatch over bad checksum
        priority if (count_upd < phc_pkg::HDR_LEN) begin
            res.status = phc_pkg::STATUS_SHORT;
        end else if (excess != {1'b0, lc_upd[15:4]}) begin
            res.status = phc_pkg::STATUS_LEN_ERR;
        end else if (chk_upd != sum_upd) begin
            res.status = phc_pkg::STATUS_CHECK_ERR;
        end else begin
            res.status = phc_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/phc_out_buf.sv =====
// Two-entry result register with skid slot between the decision logic and the master port.
`timescale 1ns / 1ps
`default_nettype none

module phc_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire phc_pkg::result_t push_data,
    output logic                  space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output phc_pkg::result_t      out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    phc_pkg::result_t main_reg, main_next;
    phc_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // no push possible while the skid slot is full
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot full with main slot empty");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(push && main_valid_reg && !out_ready))
        else $error("skid slot filled without a stalled result");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready) |=> (main_valid_reg && $stable(main_reg)))
        else $error("stalled result changed");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("result pushed into full buffer");

endmodule

`default_nettype wire

// ===== rtl/core/packet_header_checker_top.sv =====
// Top level of the packet header checker.
//
// Slave stream: one datagram byte per transaction in s_tdata[7:0], s_tlast on
// the final byte. Master stream: one transaction per datagram, issued after its
// last byte; m_tuser carries the status, m_tdata the unpacked header fields and
// the saturated total length.
// The result is registered in the output buffer's main slot, or in its skid slot
// while the main slot is stalled, after the transaction that carried the last byte.
// Throughput: one byte per cycle while s_tready is high, set by the header capture and
// byte-wide checksum add between the state registers and the result register.
// Reset (aresetn low, synchronous) clears the byte count, the running sum, the
// captured header and both result slots.
// A stalled receiver holds the current result; one more result fits in a skid
// slot, and s_tready drops only while both slots are full.
`timescale 1ns / 1ps
`default_nettype none

module packet_header_checker_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [3:0] msg_kind, [7:4] version, [11:8] channel, [23:12] declared_len,
    // [55:24] serial_id, [87:56] send_time, [100:88] total_length, [103:101] zero
    output logic [phc_pkg::TDATA_W-1:0]      m_tdata,
    output logic [phc_pkg::TUSER_W-1:0]      m_tuser    // [1:0] status
);

    logic             accept;
    logic             res_valid;
    logic             space;
    phc_pkg::result_t res;
    phc_pkg::result_t out_res;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    phc_hdr_acc u_hdr_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    phc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {3'b000,
                      out_res.total_length,
                      out_res.send_time,
                      out_res.serial_id,
                      out_res.declared_len,
                      out_res.channel,
                      out_res.version,
                      out_res.msg_kind};

endmodule

`default_nettype wire
